### sv/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg: shared types for the segment intersection classifier
// Transaction structs for both channels, relation codes, saturation values.
// ----------------------------------------------------------------------------
package sic_pkg;

	localparam int FIELD_W = 16;
	localparam int PARAM_W = 32;

	// relation codes
	typedef enum logic [2:0] {
		REL_NONE     = 3'd0,
		REL_CROSS    = 3'd1,
		REL_PARALLEL = 3'd2,
		REL_APART    = 3'd3,
		REL_TOUCH    = 3'd4,
		REL_OVERLAP  = 3'd5
	} rel_t;

	localparam logic signed [PARAM_W-1:0] SAT_POS = {1'b0, {(PARAM_W-1){1'b1}}};
	localparam logic signed [PARAM_W-1:0] SAT_NEG = {1'b1, {(PARAM_W-1){1'b0}}};

	// input transaction: endpoints of AB and CD
	typedef struct packed {
		logic signed [FIELD_W-1:0] ax;
		logic signed [FIELD_W-1:0] ay;
		logic signed [FIELD_W-1:0] bx;
		logic signed [FIELD_W-1:0] by;
		logic signed [FIELD_W-1:0] cx;
		logic signed [FIELD_W-1:0] cy;
		logic signed [FIELD_W-1:0] dx;
		logic signed [FIELD_W-1:0] dy;
	} seg_t;

	// result transaction
	typedef struct packed {
		rel_t                      relation;
		logic signed [PARAM_W-1:0] param_ab;
		logic signed [PARAM_W-1:0] param_cd;
		logic                      params_valid;
	} res_t;

endpackage

### sv/sic_fifo.sv
// ----------------------------------------------------------------------------
// sic_fifo: small show-ahead queue
// Register array with head and tail pointers; head entry is visible while
// the queue is not empty.
// ----------------------------------------------------------------------------
module sic_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end
endmodule

### sv/sic_front.sv
// ----------------------------------------------------------------------------
// sic_front: cross products and classification
// Three stages: differences, products, determinants; the relation is
// settled from the last stage on its way into the queue.
// ----------------------------------------------------------------------------
module sic_front import sic_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      take,
	input  seg_t                      seg,
	output logic                      valid,
	output rel_t                      rel,
	output logic                      pv,
	output logic signed [2*COORD_BITS+2:0] det,
	output logic signed [2*COORD_BITS+2:0] n1,
	output logic signed [2*COORD_BITS+2:0] n2
);
	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int PRW = 2 * C + 2;
	localparam int DTW = 2 * C + 3;

	logic signed [C-1:0] ax_c, ay_c, bx_c, by_c, cx_c, cy_c, dx_c, dy_c;
	logic                vert;

	// low coordinate bits, sign taken from the top one
	assign ax_c = signed'(C'($unsigned(seg.ax)));
	assign ay_c = signed'(C'($unsigned(seg.ay)));
	assign bx_c = signed'(C'($unsigned(seg.bx)));
	assign by_c = signed'(C'($unsigned(seg.by)));
	assign cx_c = signed'(C'($unsigned(seg.cx)));
	assign cy_c = signed'(C'($unsigned(seg.cy)));
	assign dx_c = signed'(C'($unsigned(seg.dx)));
	assign dy_c = signed'(C'($unsigned(seg.dy)));
	assign vert = (ax_c == bx_c);

	logic                 v_s1, v_s2, v_s3;
	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [C-1:0]  p0_s1, p1_s1, q0_s1, q1_s1;

	logic signed [PRW-1:0] uxvy_s2, uyvx_s2, wxvy_s2, wyvx_s2, wxuy_s2, wyux_s2;
	logic signed [C-1:0]   lo1_s2, hi1_s2, lo2_s2, hi2_s2;

	logic signed [DTW-1:0] det_s3, n1_s3, n2_s3;
	rel_t                  pcls_s3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: edge vectors and projection axis
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= DW'(bx_c) - DW'(ax_c);
			uy_s1 <= DW'(by_c) - DW'(ay_c);
			vx_s1 <= DW'(dx_c) - DW'(cx_c);
			vy_s1 <= DW'(dy_c) - DW'(cy_c);
			wx_s1 <= DW'(cx_c) - DW'(ax_c);
			wy_s1 <= DW'(cy_c) - DW'(ay_c);
			p0_s1 <= vert ? ay_c : ax_c;
			p1_s1 <= vert ? by_c : bx_c;
			q0_s1 <= vert ? cy_c : cx_c;
			q1_s1 <= vert ? dy_c : dx_c;
		end
	end

	// stage 2: products and interval ends
	always_ff @(posedge clk) begin
		if (en) begin
			uxvy_s2 <= PRW'(ux_s1) * PRW'(vy_s1);
			uyvx_s2 <= PRW'(uy_s1) * PRW'(vx_s1);
			wxvy_s2 <= PRW'(wx_s1) * PRW'(vy_s1);
			wyvx_s2 <= PRW'(wy_s1) * PRW'(vx_s1);
			wxuy_s2 <= PRW'(wx_s1) * PRW'(uy_s1);
			wyux_s2 <= PRW'(wy_s1) * PRW'(ux_s1);
			lo1_s2  <= (p0_s1 < p1_s1) ? p0_s1 : p1_s1;
			hi1_s2  <= (p0_s1 < p1_s1) ? p1_s1 : p0_s1;
			lo2_s2  <= (q0_s1 < q1_s1) ? q0_s1 : q1_s1;
			hi2_s2  <= (q0_s1 < q1_s1) ? q1_s1 : q0_s1;
		end
	end

	// stage 3: determinant, numerators, projection class
	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= DTW'(uxvy_s2) - DTW'(uyvx_s2);
			n1_s3  <= DTW'(wxvy_s2) - DTW'(wyvx_s2);
			n2_s3  <= DTW'(wxuy_s2) - DTW'(wyux_s2);
			if (hi2_s2 < lo1_s2 || lo2_s2 > hi1_s2) pcls_s3 <= REL_APART;
			else if (hi2_s2 == lo1_s2 || lo2_s2 == hi1_s2) pcls_s3 <= REL_TOUCH;
			else pcls_s3 <= REL_OVERLAP;
		end
	end

	// final relation
	logic in_pos, in_neg;
	assign in_pos = (n1_s3 >= 0) && (n1_s3 <= det_s3) && (n2_s3 >= 0) && (n2_s3 <= det_s3);
	assign in_neg = (n1_s3 <= 0) && (n1_s3 >= det_s3) && (n2_s3 <= 0) && (n2_s3 >= det_s3);

	always_comb begin
		pv = (det_s3 != 0);
		if (pv) begin
			if (det_s3 > 0) rel = in_pos ? REL_CROSS : REL_NONE;
			else rel = in_neg ? REL_CROSS : REL_NONE;
		end else if (n1_s3 != 0 && n2_s3 != 0) begin
			rel = REL_PARALLEL;
		end else begin
			rel = pcls_s3;
		end
	end

	assign valid = v_s3;
	assign det   = det_s3;
	assign n1    = n1_s3;
	assign n2    = n2_s3;
endmodule

### sv/sic_back.sv
// ----------------------------------------------------------------------------
// sic_back: pipelined fixed-point dividers
// One saturation check stage, then one restoring quotient bit per stage for
// both parameters side by side; sign and saturation applied at the end.
// ----------------------------------------------------------------------------
module sic_back import sic_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           take,
	input  rel_t                           rel,
	input  logic                           pv,
	input  logic signed [2*COORD_BITS+2:0] det,
	input  logic signed [2*COORD_BITS+2:0] n1,
	input  logic signed [2*COORD_BITS+2:0] n2,
	output logic                           valid,
	output res_t                           res
);
	localparam int DTW  = 2 * COORD_BITS + 3;
	localparam int MW   = 2 * COORD_BITS + 2;
	localparam int QW   = PARAM_W - 1;
	localparam int XW   = MW + PARAM_W;
	localparam int NSTG = QW + 1;

	typedef struct packed {
		logic [MW-1:0] den;
		logic [XW-1:0] rem_ab;
		logic [XW-1:0] rem_cd;
		logic [QW-1:0] q_ab;
		logic [QW-1:0] q_cd;
		logic          sat_ab;
		logic          sat_cd;
		logic          neg_ab;
		logic          neg_cd;
		rel_t          rel;
		logic          pv;
	} stg_t;

	stg_t stage_s [NSTG];
	logic vld_s   [NSTG];

	// magnitudes and saturation check
	logic [DTW-1:0] det_abs, n1_abs, n2_abs;
	logic [XW-1:0]  num_ab, num_cd, den_top;
	stg_t           first;

	assign det_abs = det[DTW-1] ? DTW'(-det) : DTW'(det);
	assign n1_abs  = n1[DTW-1] ? DTW'(-n1) : DTW'(n1);
	assign n2_abs  = n2[DTW-1] ? DTW'(-n2) : DTW'(n2);
	assign num_ab  = XW'(n1_abs[MW-1:0]) << FRAC_BITS;
	assign num_cd  = XW'(n2_abs[MW-1:0]) << FRAC_BITS;
	assign den_top = XW'(det_abs[MW-1:0]) << QW;

	always_comb begin
		first.den    = det_abs[MW-1:0];
		first.rem_ab = num_ab;
		first.rem_cd = num_cd;
		first.q_ab   = '0;
		first.q_cd   = '0;
		first.sat_ab = (num_ab >= den_top);
		first.sat_cd = (num_cd >= den_top);
		first.neg_ab = n1[DTW-1] ^ det[DTW-1];
		first.neg_cd = n2[DTW-1] ^ det[DTW-1];
		first.rel    = rel;
		first.pv     = pv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= take;
	end

	always_ff @(posedge clk) begin
		if (en) stage_s[0] <= first;
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j < NSTG; j++) begin : g_stage
		localparam int K = QW - j;
		stg_t          nxt;
		logic [XW-1:0] dsh;

		assign dsh = XW'(stage_s[j-1].den) << K;

		always_comb begin
			nxt = stage_s[j-1];
			if (stage_s[j-1].rem_ab >= dsh) begin
				nxt.rem_ab  = stage_s[j-1].rem_ab - dsh;
				nxt.q_ab[K] = 1'b1;
			end
			if (stage_s[j-1].rem_cd >= dsh) begin
				nxt.rem_cd  = stage_s[j-1].rem_cd - dsh;
				nxt.q_cd[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j] <= 1'b0;
			else if (en) vld_s[j] <= vld_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) stage_s[j] <= nxt;
		end
	end

	// sign, saturation and zero determinant
	logic signed [PARAM_W-1:0] mag_ab, mag_cd;
	assign mag_ab = signed'({1'b0, stage_s[NSTG-1].q_ab});
	assign mag_cd = signed'({1'b0, stage_s[NSTG-1].q_cd});

	always_comb begin
		res.relation     = stage_s[NSTG-1].rel;
		res.params_valid = stage_s[NSTG-1].pv;
		if (!stage_s[NSTG-1].pv) res.param_ab = '0;
		else if (stage_s[NSTG-1].sat_ab) res.param_ab = stage_s[NSTG-1].neg_ab ? SAT_NEG : SAT_POS;
		else res.param_ab = stage_s[NSTG-1].neg_ab ? -mag_ab : mag_ab;
		if (!stage_s[NSTG-1].pv) res.param_cd = '0;
		else if (stage_s[NSTG-1].sat_cd) res.param_cd = stage_s[NSTG-1].neg_cd ? SAT_NEG : SAT_POS;
		else res.param_cd = stage_s[NSTG-1].neg_cd ? -mag_cd : mag_cd;
	end

	assign valid = vld_s[NSTG-1];
endmodule

### sv/segment_intersection_classifier.sv
// ----------------------------------------------------------------------------
// segment_intersection_classifier: 2D segment pair relation and parameters
//
//   channel   handshake          payload   accepted when
//   input     push / full        seg       push && !full
//   result    empty / pop        res       pop && !empty
//
// One pair per cycle sustained while the result queue is popped; a result
// passes through 3 front stages, the 4-entry mid queue, 32 divider stages and
// the 2-entry result queue. The divider pipeline in the back part sets latency.
// Front and back stall separately: front holds while the mid queue is full,
// back holds while the result queue is full. Reset empties both queues.
// ----------------------------------------------------------------------------
module segment_intersection_classifier import sic_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  seg_t seg,
	output logic empty,
	input  logic pop,
	output res_t res
);
	localparam int DTW   = 2 * COORD_BITS + 3;
	localparam int MID_W = $bits(rel_t) + 1 + 3 * DTW;

	logic                  f_en, f_valid, f_pv;
	rel_t                  f_rel;
	logic signed [DTW-1:0] f_det, f_n1, f_n2;
	logic                  mid_full, mid_empty;
	logic [MID_W-1:0]      mid_wdata, mid_rdata;
	logic                  b_en, b_take, b_valid, out_full;
	rel_t                  m_rel;
	logic                  m_pv;
	logic signed [DTW-1:0] m_det, m_n1, m_n2;
	res_t                  b_res;

	// front side
	assign f_en = !mid_full;
	assign full = mid_full;

	sic_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (f_en),
		.take   (push),
		.seg    (seg),
		.valid  (f_valid),
		.rel    (f_rel),
		.pv     (f_pv),
		.det    (f_det),
		.n1     (f_n1),
		.n2     (f_n2)
	);

	// queue between front and back
	assign mid_wdata = {f_rel, f_pv, f_det, f_n1, f_n2};

	sic_fifo #(.W(MID_W), .DEPTH(4)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid && f_en),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (b_take),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign {m_rel, m_pv, m_det, m_n1, m_n2} = mid_rdata;

	// back side
	assign b_en   = !out_full;
	assign b_take = b_en && !mid_empty;

	sic_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (b_en),
		.take   (b_take),
		.rel    (m_rel),
		.pv     (m_pv),
		.det    (m_det),
		.n1     (m_n1),
		.n2     (m_n2),
		.valid  (b_valid),
		.res    (b_res)
	);

	// result queue
	sic_fifo #(.W($bits(res_t)), .DEPTH(2)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_valid && b_en),
		.wdata  (b_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res),
		.empty  (empty)
	);
endmodule

### sv/sic_checker.sv
// ----------------------------------------------------------------------------
// sic_checker: port-level checks for the classifier
// Result consistency and queue behavior seen from the ports.
// ----------------------------------------------------------------------------
module sic_checker import sic_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input res_t res
);
	// parameters only come with a crossing or non-crossing class
	a_valid_class: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && res.params_valid |-> (res.relation == REL_NONE || res.relation == REL_CROSS))
		else $error("params_valid with a degenerate relation");

	// zero determinant gives zero parameters
	a_zero_params: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !res.params_valid |-> (res.param_ab == 0 && res.param_cd == 0))
		else $error("nonzero parameters without params_valid");

	// waiting result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(res))
		else $error("result changed while waiting");

	// queues come out of reset empty
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");
endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.res    (res)
);
